>>> hdl/fdc_pkg.sv
// fdc_pkg: shared constants, command/status types and the CRC step
// for the frame deframer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

    localparam int BUF_BYTES   = 64;
    localparam int PTR_W       = $clog2(BUF_BYTES);
    localparam int CNT_W       = PTR_W + 1;
    localparam int MAX_PAYLOAD = 58;
    localparam int HDR_BYTES   = 4;
    localparam int CRC_BYTES   = 2;

    localparam logic [7:0]  START_RESET = 8'hAA;
    localparam logic [15:0] CRC_INIT_V  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_LEN_ERR = 2'd2;
    localparam logic [1:0] KIND_CRC_ERR = 2'd3;

    typedef enum logic [1:0] {IDX_HOLD, IDX_CLR, IDX_INC, IDX_BODY} idx_op_t;
    typedef enum logic [1:0] {DROP_NONE, DROP_ONE, DROP_FRAME} drop_op_t;
    typedef enum logic [1:0] {CRC_HOLD, CRC_INIT, CRC_UPD} crc_op_t;
    typedef enum logic [2:0] {EMIT_NONE, EMIT_DATA, EMIT_EMPTY,
                              EMIT_LENERR, EMIT_CRCERR} emit_op_t;

    typedef struct packed {
        logic     push;
        logic     rd;
        idx_op_t  idx_op;
        crc_op_t  crc_op;
        logic     cap_lo;
        logic     cap_hi;
        logic     cap_type;
        logic     cap_rxlo;
        drop_op_t drop;
        emit_op_t emit;
    } fdc_cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic head_is_start;
        logic fill_lt_hdr;
        logic len_bad;
        logic fill_lt_frame;
        logic body_byte;
        logic crc_lo;
        logic crc_ok;
        logic plen_zero;
        logic last_payload;
        logic out_free;
    } fdc_status_t;

    // one byte of CRC-16, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/fdc_if.sv
// fdc_if: valid/ready channel interfaces for received bytes and results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface fdc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface fdc_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [5:0]  data_len;
    logic [7:0]  payload_byte;
    logic        last;
    logic [31:0] error_count;
    modport source (output valid, output kind, output frame_type, output data_len,
                    output payload_byte, output last, output error_count,
                    input ready);
    modport sink (input valid, input kind, input frame_type, input data_len,
                  input payload_byte, input last, input error_count,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/fdc_datapath.sv
// fdc_datapath: circular frame buffer, header/CRC registers, error counter
// and output register. Depends on fdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdc_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fdc_pkg::fdc_cmd_t   cmd,
    output fdc_pkg::fdc_status_t     status,
    input  wire logic [7:0]          start_byte,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic [1:0]               out_kind,
    output logic [7:0]               out_type,
    output logic [5:0]               out_plen,
    output logic [7:0]               out_data,
    output logic                     out_last,
    output logic [31:0]              out_errors
);

    logic [7:0] mem [fdc_pkg::BUF_BYTES];

    logic [fdc_pkg::PTR_W-1:0] head_reg, head_next;
    logic [fdc_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic [fdc_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [7:0]  rd_data_reg;
    logic [15:0] crc_reg;
    logic [7:0]  len_lo_reg, len_hi_reg, type_reg, rxlo_reg;
    logic [31:0] err_reg, err_next;
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_type_reg, out_data_reg;
    logic [5:0]  out_plen_reg;
    logic        out_last_reg;
    logic [31:0] out_err_reg;

    logic [5:0]                plen;
    logic [fdc_pkg::CNT_W-1:0] plen_w, flen;
    logic [fdc_pkg::PTR_W-1:0] wr_addr, rd_addr;
    logic                      out_free;

    assign plen    = len_lo_reg[5:0];
    assign plen_w  = fdc_pkg::CNT_W'(plen);
    assign flen    = plen_w + fdc_pkg::CNT_W'(fdc_pkg::HDR_BYTES + fdc_pkg::CRC_BYTES);
    assign wr_addr = head_reg + fill_reg[fdc_pkg::PTR_W-1:0];
    assign rd_addr = head_reg + idx_reg[fdc_pkg::PTR_W-1:0];
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        status.fill_zero     = (fill_reg == '0);
        status.head_is_start = (rd_data_reg == start_byte);
        status.fill_lt_hdr   = (fill_reg < fdc_pkg::CNT_W'(fdc_pkg::HDR_BYTES));
        status.len_bad       = (len_hi_reg != 8'd0) ||
                               (len_lo_reg > 8'(fdc_pkg::MAX_PAYLOAD));
        status.fill_lt_frame = (fill_reg < flen);
        status.body_byte     = (idx_reg <= plen_w + fdc_pkg::CNT_W'(fdc_pkg::HDR_BYTES));
        status.crc_lo        = (idx_reg == plen_w + fdc_pkg::CNT_W'(fdc_pkg::HDR_BYTES + 1));
        status.crc_ok        = ({rd_data_reg, rxlo_reg} == crc_reg);
        status.plen_zero     = (plen == 6'd0);
        status.last_payload  = (idx_reg == plen_w + fdc_pkg::CNT_W'(fdc_pkg::HDR_BYTES));
        status.out_free      = out_free;
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.push && fill_reg < fdc_pkg::CNT_W'(fdc_pkg::BUF_BYTES))
            fill_next = fill_reg + 1'b1;
        case (cmd.drop)
            fdc_pkg::DROP_ONE:
            begin
                head_next = head_reg + 1'b1;
                fill_next = fill_reg - 1'b1;
            end
            fdc_pkg::DROP_FRAME:
            begin
                head_next = head_reg + flen[fdc_pkg::PTR_W-1:0];
                fill_next = fill_reg - flen;
            end
            default: ;
        endcase

        case (cmd.idx_op)
            fdc_pkg::IDX_CLR:  idx_next = '0;
            fdc_pkg::IDX_INC:  idx_next = idx_reg + 1'b1;
            fdc_pkg::IDX_BODY: idx_next = fdc_pkg::CNT_W'(fdc_pkg::HDR_BYTES);
            default:           idx_next = idx_reg;
        endcase

        if (cmd.emit == fdc_pkg::EMIT_LENERR || cmd.emit == fdc_pkg::EMIT_CRCERR)
            err_next = err_reg + 32'd1;
        else
            err_next = err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
            err_reg  <= err_next;
            if (cmd.emit != fdc_pkg::EMIT_NONE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && fill_reg < fdc_pkg::CNT_W'(fdc_pkg::BUF_BYTES))
            mem[wr_addr] <= rx_byte;
        if (cmd.rd)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.crc_op)
            fdc_pkg::CRC_INIT: crc_reg <= fdc_pkg::CRC_INIT_V;
            fdc_pkg::CRC_UPD:  crc_reg <= fdc_pkg::crc_byte(crc_reg, rd_data_reg);
            default: ;
        endcase
        if (cmd.cap_lo)
            len_lo_reg <= rd_data_reg;
        if (cmd.cap_hi)
            len_hi_reg <= rd_data_reg;
        if (cmd.cap_type)
            type_reg <= rd_data_reg;
        if (cmd.cap_rxlo)
            rxlo_reg <= rd_data_reg;

        case (cmd.emit)
            fdc_pkg::EMIT_DATA:
            begin
                out_kind_reg <= fdc_pkg::KIND_DATA;
                out_type_reg <= type_reg;
                out_plen_reg <= plen;
                out_data_reg <= rd_data_reg;
                out_last_reg <= status.last_payload;
                out_err_reg  <= err_next;
            end
            fdc_pkg::EMIT_EMPTY:
            begin
                out_kind_reg <= fdc_pkg::KIND_EMPTY;
                out_type_reg <= type_reg;
                out_plen_reg <= 6'd0;
                out_data_reg <= 8'd0;
                out_last_reg <= 1'b1;
                out_err_reg  <= err_next;
            end
            fdc_pkg::EMIT_LENERR, fdc_pkg::EMIT_CRCERR:
            begin
                out_kind_reg <= (cmd.emit == fdc_pkg::EMIT_LENERR) ?
                                fdc_pkg::KIND_LEN_ERR : fdc_pkg::KIND_CRC_ERR;
                out_type_reg <= 8'd0;
                out_plen_reg <= 6'd0;
                out_data_reg <= 8'd0;
                out_last_reg <= 1'b1;
                out_err_reg  <= err_next;
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_type   = out_type_reg;
    assign out_plen   = out_plen_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;
    assign out_errors = out_err_reg;

endmodule

`default_nettype wire

>>> hdl/fdc_ctrl.sv
// fdc_ctrl: sequencer for byte intake, frame scan, CRC check and payload
// emission. Depends on fdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rx_valid,
    output logic                       rx_ready,
    input  wire fdc_pkg::fdc_status_t  status,
    output fdc_pkg::fdc_cmd_t          cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_HEAD, S_LEN0, S_LEN1, S_TYPE, S_CRCRUN,
        S_PREAD, S_PEMIT, S_EMPTY, S_LENERR, S_CRCERR
    } state_t;

    state_t state_reg, state_next;

    assign rx_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.fill_zero)
                    state_next = S_IDLE;
                else
                begin
                    cmd.rd     = 1'b1;
                    cmd.idx_op = fdc_pkg::IDX_INC;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (!status.head_is_start)
                begin
                    cmd.drop   = fdc_pkg::DROP_ONE;
                    cmd.idx_op = fdc_pkg::IDX_CLR;
                    state_next = S_SCAN;
                end
                else if (status.fill_lt_hdr)
                begin
                    cmd.idx_op = fdc_pkg::IDX_CLR;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    cmd.idx_op = fdc_pkg::IDX_INC;
                    cmd.crc_op = fdc_pkg::CRC_INIT;
                    state_next = S_LEN0;
                end
            end
            S_LEN0:
            begin
                cmd.cap_lo = 1'b1;
                cmd.crc_op = fdc_pkg::CRC_UPD;
                cmd.rd     = 1'b1;
                cmd.idx_op = fdc_pkg::IDX_INC;
                state_next = S_LEN1;
            end
            S_LEN1:
            begin
                cmd.cap_hi = 1'b1;
                cmd.crc_op = fdc_pkg::CRC_UPD;
                cmd.rd     = 1'b1;
                cmd.idx_op = fdc_pkg::IDX_INC;
                state_next = S_TYPE;
            end
            S_TYPE:
            begin
                cmd.cap_type = 1'b1;
                cmd.crc_op   = fdc_pkg::CRC_UPD;
                if (status.len_bad)
                begin
                    cmd.idx_op = fdc_pkg::IDX_CLR;
                    state_next = S_LENERR;
                end
                else if (status.fill_lt_frame)
                begin
                    cmd.idx_op = fdc_pkg::IDX_CLR;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    cmd.idx_op = fdc_pkg::IDX_INC;
                    state_next = S_CRCRUN;
                end
            end
            S_CRCRUN:
            begin
                if (status.body_byte)
                begin
                    cmd.crc_op = fdc_pkg::CRC_UPD;
                    cmd.rd     = 1'b1;
                    cmd.idx_op = fdc_pkg::IDX_INC;
                end
                else if (status.crc_lo)
                begin
                    cmd.cap_rxlo = 1'b1;
                    cmd.rd       = 1'b1;
                    cmd.idx_op   = fdc_pkg::IDX_INC;
                end
                else if (!status.crc_ok)
                begin
                    cmd.idx_op = fdc_pkg::IDX_CLR;
                    state_next = S_CRCERR;
                end
                else if (status.plen_zero)
                begin
                    cmd.idx_op = fdc_pkg::IDX_CLR;
                    state_next = S_EMPTY;
                end
                else
                begin
                    cmd.idx_op = fdc_pkg::IDX_BODY;
                    state_next = S_PREAD;
                end
            end
            S_PREAD:
            begin
                cmd.rd     = 1'b1;
                cmd.idx_op = fdc_pkg::IDX_INC;
                state_next = S_PEMIT;
            end
            S_PEMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = fdc_pkg::EMIT_DATA;
                    if (status.last_payload)
                    begin
                        cmd.drop   = fdc_pkg::DROP_FRAME;
                        cmd.idx_op = fdc_pkg::IDX_CLR;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.rd     = 1'b1;
                        cmd.idx_op = fdc_pkg::IDX_INC;
                    end
                end
            end
            S_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = fdc_pkg::EMIT_EMPTY;
                    cmd.drop   = fdc_pkg::DROP_FRAME;
                    state_next = S_SCAN;
                end
            end
            S_LENERR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = fdc_pkg::EMIT_LENERR;
                    cmd.drop   = fdc_pkg::DROP_ONE;
                    state_next = S_SCAN;
                end
            end
            S_CRCERR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = fdc_pkg::EMIT_CRCERR;
                    cmd.drop   = fdc_pkg::DROP_ONE;
                    state_next = S_SCAN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> hdl/frame_deframer_crc16_unit.sv
// Byte-stream frame deframer with CRC-16/CCITT-FALSE check: top level.
// Depends on fdc_pkg, fdc_if, fdc_ctrl and fdc_datapath.
//
// Takes one received byte per word on rx_ch and emits payload bytes, empty-
// frame marks and error events on res_ch. Frames are: start byte, 16-bit
// little-endian length (at most 58), type byte, payload, little-endian CRC
// over length, type and payload. A byte is taken only while the sequencer is
// idle; the buffer is one 64-entry memory with one read per cycle, so work
// goes in order: an incoming byte is accepted, each front byte is checked by
// a scan and a head compare (a dropped byte included), a final scan runs when
// the buffer ends up empty, a buffered header is parsed, a CRC pass runs once
// a frame is complete, the first payload byte is fetched, and results go out
// one per cycle while res_ch is not stalled. After a bad frame the buffer is
// rescanned from the next byte. start_byte is the only register, at address
// 0 of the APB port (reset 0xAA).
`timescale 1ns / 1ps
`default_nettype none

module frame_deframer_crc16_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    fdc_rx_if.sink           rx_ch,
    fdc_res_if.source        res_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    fdc_pkg::fdc_cmd_t    cmd;
    fdc_pkg::fdc_status_t status;
    logic [7:0] start_reg;
    logic       sel_start;

    assign pready    = 1'b1;
    assign sel_start = (paddr[2] == 1'b0);
    assign prdata    = sel_start ? {24'd0, start_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_reg <= fdc_pkg::START_RESET;
        else if (psel && penable && pwrite && pready && sel_start)
            start_reg <= pwdata[7:0];
    end

    fdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_ch.valid),
        .rx_ready (rx_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    fdc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .start_byte (start_reg),
        .rx_byte    (rx_ch.rx_byte),
        .out_ready  (res_ch.ready),
        .out_valid  (res_ch.valid),
        .out_kind   (res_ch.kind),
        .out_type   (res_ch.frame_type),
        .out_plen   (res_ch.data_len),
        .out_data   (res_ch.payload_byte),
        .out_last   (res_ch.last),
        .out_errors (res_ch.error_count)
    );

endmodule

`default_nettype wire

>>> test/testbench.sv
// testbench: self-checking bench for frame_deframer_crc16_unit. It drives good, corrupt,
// oversize and truncated frames plus noise bytes and checks every result word.
// Depends on fdc_pkg, fdc_if and the deframer RTL.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_type;
        logic [5:0]  data_len;
        logic [7:0]  payload_byte;
        logic        last;
        logic [31:0] error_count;
    } deframe_word_t;

    class deframe_scoreboard;
        logic [7:0]    rx_bytes[$];
        logic [31:0]   drop_cnt;
        logic [7:0]    sof_byte;
        deframe_word_t expected_q[$];
        int            mismatches;

        function new();
            drop_cnt   = 0;
            sof_byte   = fdc_pkg::START_RESET;
            mismatches = 0;
        endfunction

        function logic [15:0] frame_crc(int count);
            logic [15:0] c;
            c = 16'hFFFF;
            for (int i = 1; i <= count; i++)
            begin
                c = c ^ {rx_bytes[i], 8'h00};
                for (int b = 0; b < 8; b++)
                    c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
            end
            return c;
        endfunction

        function void add_word(ref int n, input logic [1:0] k, input logic [7:0] t,
                               input logic [5:0] pl, input logic [7:0] d, input logic l);
            deframe_word_t w;
            if (n >= 64)
                return;
            w.kind = k;
            w.frame_type = t;
            w.data_len = pl;
            w.payload_byte = d;
            w.last = l;
            w.error_count = drop_cnt;
            expected_q.push_back(w);
            n++;
        endfunction

        function void note_byte(logic [7:0] b);
            int          n;
            int          plen;
            int          flen;
            logic [7:0]  typ;
            logic [15:0] got_crc;
            n = 0;
            if (rx_bytes.size() < 64)
                rx_bytes.push_back(b);
            while (rx_bytes.size() > 0)
            begin
                if (rx_bytes[0] != sof_byte)
                begin
                    void'(rx_bytes.pop_front());
                    continue;
                end
                if (rx_bytes.size() < 4)
                    break;
                plen = {rx_bytes[2], rx_bytes[1]};
                typ = rx_bytes[3];
                if (plen > 58 || plen + 6 > 64)
                begin
                    drop_cnt++;
                    add_word(n, fdc_pkg::KIND_LEN_ERR, 8'h00, 6'd0, 8'h00, 1'b1);
                    void'(rx_bytes.pop_front());
                    continue;
                end
                flen = plen + 6;
                if (rx_bytes.size() < flen)
                    break;
                got_crc = {rx_bytes[flen - 1], rx_bytes[flen - 2]};
                if (got_crc != frame_crc(flen - 3))
                begin
                    drop_cnt++;
                    add_word(n, fdc_pkg::KIND_CRC_ERR, 8'h00, 6'd0, 8'h00, 1'b1);
                    void'(rx_bytes.pop_front());
                    continue;
                end
                if (plen == 0)
                    add_word(n, fdc_pkg::KIND_EMPTY, typ, 6'd0, 8'h00, 1'b1);
                else
                    for (int i = 0; i < plen; i++)
                        add_word(n, fdc_pkg::KIND_DATA, typ, plen[5:0], rx_bytes[4 + i],
                                 i + 1 == plen);
                for (int i = 0; i < flen; i++)
                    void'(rx_bytes.pop_front());
            end
        endfunction

        function void check_word(deframe_word_t got);
            deframe_word_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got %h", $realtime, got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                $display("%0t: word mismatch, expected %h, got %h", $realtime, want, got);
                $display("  kind %0d/%0d type %h/%h len %0d/%0d byte %h/%h last %b/%b cnt %0d/%0d",
                         want.kind, got.kind, want.frame_type, got.frame_type,
                         want.data_len, got.data_len, want.payload_byte,
                         got.payload_byte, want.last, got.last,
                         want.error_count, got.error_count);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fdc_rx_if  rx_ch();
    fdc_res_if res_ch();

    frame_deframer_crc16_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_ch   (rx_ch.sink),
        .res_ch  (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    deframe_scoreboard sb;
    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  hold_req;
    int  hold_left;
    int  bytes_sent;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // result sink
    always @(posedge clk)
    begin
        deframe_word_t w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            w.kind = res_ch.kind;
            w.frame_type = res_ch.frame_type;
            w.data_len = res_ch.data_len;
            w.payload_byte = res_ch.payload_byte;
            w.last = res_ch.last;
            w.error_count = res_ch.error_count;
            sb.check_word(w);
        end
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 600;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // keep < 0 sends the whole frame
    task automatic send_frame(input int plen, input logic [7:0] typ, input bit bad_crc,
                              input int keep);
        logic [7:0]  fr[$];
        logic [15:0] c;
        fr.push_back(sb.sof_byte);
        fr.push_back(plen[7:0]);
        fr.push_back(plen[15:8]);
        fr.push_back(typ);
        for (int i = 0; i < plen; i++)
            fr.push_back(8'($urandom_range(255)));
        c = 16'hFFFF;
        for (int i = 1; i < fr.size(); i++)
        begin
            c = c ^ {fr[i], 8'h00};
            for (int b = 0; b < 8; b++)
                c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        if (bad_crc)
            c = c ^ 16'($urandom_range(65535, 1));
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
        if (keep < 0 || keep > fr.size())
            keep = fr.size();
        for (int i = 0; i < keep; i++)
            send_byte(fr[i]);
    endtask

    task automatic send_len_err(input int plen);
        send_byte(sb.sof_byte);
        send_byte(plen[7:0]);
        send_byte(plen[15:8]);
        send_byte(8'($urandom_range(255)));
    endtask

    task automatic drain();
        @(posedge clk);
        rx_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_start(input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {24'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.sof_byte = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_phase(input int nbytes);
        int r;
        int stop;
        stop = bytes_sent + nbytes;
        while (bytes_sent < stop)
        begin
            r = $urandom_range(99);
            if (r < 60)
                send_frame(($urandom_range(9) == 0) ? $urandom_range(58) : $urandom_range(6),
                           8'($urandom_range(255)), 1'b0, -1);
            else if (r < 70)
                send_frame($urandom_range(8), 8'($urandom_range(255)), 1'b1, -1);
            else if (r < 77)
                send_len_err($urandom_range(65535, 59));
            else if (r < 90)
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
            else
                send_frame($urandom_range(10), 8'($urandom_range(255)), 1'b0,
                           $urandom_range(6, 1));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'h0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = 1'b0;
        hold_left = 0;
        bytes_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset start byte
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, 8'hFF, 1'b0, -1);
        send_frame(1, 8'h00, 1'b0, -1);
        send_frame(2, 8'h5A, 1'b1, -1);
        send_len_err(59);
        send_len_err(65535);
        send_frame(58, 8'hA5, 1'b0, -1);
        send_frame(3, 8'h11, 1'b0, 3);
        send_frame(0, 8'h80, 1'b0, -1);
        drain();

        // no idling, with a long receiver hold-off
        write_start(8'h00);
        hold_req = 1'b1;
        send_frame(40, 8'h3C, 1'b0, -1);
        send_frame(20, 8'hC3, 1'b0, -1);
        random_phase(20);
        drain();

        write_start(8'hFF);
        tx_idle_pct = 77;
        random_phase(20);
        drain();

        write_start(8'($urandom_range(255)));
        tx_idle_pct = 0;
        rx_stall_pct = 77;
        random_phase(20);
        drain();

        write_start(fdc_pkg::START_RESET);
        tx_idle_pct = 21;
        rx_stall_pct = 21;
        random_phase(20);
        drain();

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> sim.f
hdl/fdc_pkg.sv
hdl/fdc_if.sv
hdl/fdc_datapath.sv
hdl/fdc_ctrl.sv
hdl/frame_deframer_crc16_unit.sv
test/testbench.sv
